// File: rtl/slirq_pkg.sv
// Shared types, codes and bus addresses for the scanline IRQ counter.
// No dependencies; every other file in rtl/ refers to this package.
package slirq_pkg;

  // Kind of access carried by one input beat
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_VIDEO = 2'd3
  } action_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_IDLE_TIMEOUT   = 1'b0,
    CFG_FRAME_END_LINE = 1'b1
  } cfg_index_e;

  localparam int unsigned CfgWidth = 8;

  localparam logic [7:0] IdleTimeoutReset  = 8'd100;
  localparam logic [7:0] FrameEndLineReset = 8'd241;
  localparam logic [7:0] FactorReset       = 8'hFF;
  localparam logic [7:0] IdleMax           = 8'hFF;

  // CPU register map
  localparam logic [15:0] AddrLineTarget = 16'h5203;
  localparam logic [15:0] AddrStatus     = 16'h5204;
  localparam logic [15:0] AddrProdLo     = 16'h5205;
  localparam logic [15:0] AddrProdHi     = 16'h5206;
  localparam logic [15:0] AddrVectorLo   = 16'hFFFA;
  localparam logic [15:0] AddrVectorHi   = 16'hFFFB;

  // Name-table window 0x2000..0x2FFF, matched on the top nibble
  localparam logic [3:0] NameTableNibble = 4'h2;

  localparam logic [1:0] RepeatFull = 2'd3;

  typedef struct packed {
    action_e     action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic       frame_active;
  } out_beat_t;

  // Core flags exported for checking
  typedef struct packed {
    logic irq_pending;
    logic irq_level;
    logic in_frame;
  } core_stat_t;

  // Result buffer occupancy
  typedef struct packed {
    logic head_valid;
    logic skid_valid;
  } buf_stat_t;

endpackage

// File: rtl/slirq_core.sv
// Scanline detector state, CPU register file and 8x8 multiplier.
// Applies one accepted beat per cycle; depends on slirq_pkg.
module slirq_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  slirq_pkg::cfg_index_e          cfg_index_i,
  input  logic [slirq_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                           step_i,
  input  slirq_pkg::in_beat_t            beat_i,
  output slirq_pkg::out_beat_t           result_o,
  output slirq_pkg::core_stat_t          stat_o
);

  logic [7:0]  idle_timeout_q, frame_end_line_q;
  logic        seen_q, seen_d;
  logic [7:0]  idle_q, idle_d;
  logic [15:0] last_addr_q, last_addr_d;
  logic [1:0]  repeat_q, repeat_d;
  logic        in_frame_q, in_frame_d;
  logic [7:0]  line_q, line_d;
  logic [7:0]  target_q, target_d;
  logic        enable_q, enable_d;
  logic        pending_q, pending_d;
  logic        level_q, level_d;
  logic [7:0]  factor_a_q, factor_a_d;
  logic [7:0]  factor_b_q, factor_b_d;

  logic [15:0] product;
  logic [7:0]  idle_inc;
  logic [7:0]  line_inc;
  logic [1:0]  repeat_inc;
  logic [7:0]  rd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q   <= slirq_pkg::IdleTimeoutReset;
      frame_end_line_q <= slirq_pkg::FrameEndLineReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        slirq_pkg::CFG_IDLE_TIMEOUT:   idle_timeout_q   <= cfg_wdata_i;
        slirq_pkg::CFG_FRAME_END_LINE: frame_end_line_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign product    = 16'(factor_a_q) * 16'(factor_b_q);
  assign idle_inc   = (idle_q != slirq_pkg::IdleMax) ? idle_q + 8'd1 : idle_q;
  assign line_inc   = line_q + 8'd1;
  assign repeat_inc = repeat_q + 2'd1;

  // Next state for the beat being accepted
  always_comb begin
    seen_d      = seen_q;
    idle_d      = idle_q;
    last_addr_d = last_addr_q;
    repeat_d    = repeat_q;
    in_frame_d  = in_frame_q;
    line_d      = line_q;
    target_d    = target_q;
    enable_d    = enable_q;
    pending_d   = pending_q;
    level_d     = level_q;
    factor_a_d  = factor_a_q;
    factor_b_d  = factor_b_q;
    rd          = 8'd0;

    unique case (beat_i.action)
      slirq_pkg::ACT_TICK: begin
        if (seen_q) begin
          idle_d = 8'd0;
        end else begin
          idle_d = idle_inc;
          if (idle_inc == idle_timeout_q) in_frame_d = 1'b0;
        end
        seen_d = 1'b0;
      end

      slirq_pkg::ACT_READ: begin
        unique case (beat_i.address)
          slirq_pkg::AddrStatus: begin
            rd        = {pending_q, in_frame_q, 6'd0};
            pending_d = 1'b0;
            level_d   = 1'b0;
          end
          slirq_pkg::AddrProdLo: rd = product[7:0];
          slirq_pkg::AddrProdHi: rd = product[15:8];
          slirq_pkg::AddrVectorLo, slirq_pkg::AddrVectorHi: begin
            in_frame_d = 1'b0;
            line_d     = 8'd0;
            pending_d  = 1'b0;
            level_d    = 1'b0;
          end
          default: ;
        endcase
      end

      slirq_pkg::ACT_WRITE: begin
        unique case (beat_i.address)
          slirq_pkg::AddrLineTarget: target_d = beat_i.write_data;
          slirq_pkg::AddrStatus: begin
            enable_d = beat_i.write_data[7];
            if (beat_i.write_data[7] && pending_q) level_d = 1'b1;
          end
          slirq_pkg::AddrProdLo: factor_a_d = beat_i.write_data;
          slirq_pkg::AddrProdHi: factor_b_d = beat_i.write_data;
          default: ;
        endcase
      end

      slirq_pkg::ACT_VIDEO: begin
        seen_d = 1'b1;
        if (repeat_q == 2'd0 && beat_i.address[15:12] == slirq_pkg::NameTableNibble) begin
          last_addr_d = beat_i.address;
          repeat_d    = 2'd1;
        end else if (beat_i.address != last_addr_q) begin
          repeat_d = 2'd0;
        end else if (repeat_q != slirq_pkg::RepeatFull) begin
          repeat_d = repeat_inc;
          // Third matching fetch: start a frame, advance a line, or end the frame at the end line
          if (repeat_inc == slirq_pkg::RepeatFull) begin
            if (!in_frame_q) begin
              in_frame_d = 1'b1;
              line_d     = 8'd0;
              level_d    = 1'b0;
            end else if (line_inc == frame_end_line_q) begin
              in_frame_d = 1'b0;
              line_d     = 8'd0;
              pending_d  = 1'b0;
              level_d    = 1'b0;
            end else begin
              line_d = line_inc;
              if (line_inc == target_q) begin
                pending_d = 1'b1;
                if (enable_q) level_d = 1'b1;
              end
            end
          end
        end
      end

      default: ;
    endcase
  end

  // Commit state on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      idle_q      <= 8'd0;
      last_addr_q <= 16'd0;
      repeat_q    <= 2'd0;
      in_frame_q  <= 1'b0;
      line_q      <= 8'd0;
      target_q    <= 8'd0;
      enable_q    <= 1'b0;
      pending_q   <= 1'b0;
      level_q     <= 1'b0;
      factor_a_q  <= slirq_pkg::FactorReset;
      factor_b_q  <= slirq_pkg::FactorReset;
    end else if (step_i) begin
      seen_q      <= seen_d;
      idle_q      <= idle_d;
      last_addr_q <= last_addr_d;
      repeat_q    <= repeat_d;
      in_frame_q  <= in_frame_d;
      line_q      <= line_d;
      target_q    <= target_d;
      enable_q    <= enable_d;
      pending_q   <= pending_d;
      level_q     <= level_d;
      factor_a_q  <= factor_a_d;
      factor_b_q  <= factor_b_d;
    end
  end

  assign result_o.read_data    = rd;
  assign result_o.irq_out      = level_d;
  assign result_o.frame_active = in_frame_d;

  assign stat_o.irq_pending = pending_q;
  assign stat_o.irq_level   = level_q;
  assign stat_o.in_frame    = in_frame_q;

endmodule

// File: rtl/slirq_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Lets input acceptance ride out an output stall until the skid register is full; depends on slirq_pkg.
module slirq_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  slirq_pkg::out_beat_t  beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output slirq_pkg::out_beat_t  out_beat_o,
  output slirq_pkg::buf_stat_t  stat_o
);

  logic                 head_v_q, head_v_d;
  logic                 skid_v_q, skid_v_d;
  slirq_pkg::out_beat_t head_q, head_d;
  slirq_pkg::out_beat_t skid_q, skid_d;
  logic                 pop;

  assign pop = head_v_q && out_ready_i;

  // On a pop, advance head from skid or load the new beat; else place a new beat in an empty head or behind it
  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        head_v_d = push_i;
        head_d   = beat_i;
      end
    end else if (push_i) begin
      if (!head_v_q) begin
        head_v_d = 1'b1;
        head_d   = beat_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = beat_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = head_v_q;
  assign out_beat_o        = head_q;
  assign stat_o.head_valid = head_v_q;
  assign stat_o.skid_valid = skid_v_q;

endmodule

// File: rtl/scanline_irq_counter_unit.sv
// Scanline IRQ counter top level: state update core plus result buffer.
// Results are registered in the result buffer and leave in order of acceptance.
// Throughput: one beat per cycle; input stalls only once both result slots are full.
// The state update and 8x8 multiply are combinational between the state registers
// and result register. Reset clears detector and IRQ state; factors reset to 0xFF.
module scanline_irq_counter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  slirq_pkg::cfg_index_e          cfg_index_i,
  input  logic [slirq_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  slirq_pkg::in_beat_t            in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output slirq_pkg::out_beat_t           out_beat_o
);

  logic                  accept;
  slirq_pkg::out_beat_t  result;
  slirq_pkg::core_stat_t core_stat;
  slirq_pkg::buf_stat_t  buf_stat;

  // Take a beat whenever the skid slot is free
  assign in_ready_o = !buf_stat.skid_valid;
  assign accept     = in_valid_i && in_ready_o;

  slirq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (accept),
    .beat_i      (in_beat_i),
    .result_o    (result),
    .stat_o      (core_stat)
  );

  slirq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .beat_i      (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .stat_o      (buf_stat)
  );

  // The line is never raised without a pending flag behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.irq_level |-> core_stat.irq_pending)
    else $error("irq level high without pending flag");

  // The skid slot fills only behind a full head slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_stat.skid_valid |-> buf_stat.head_valid)
    else $error("skid slot valid with empty head");

  // An accepted beat always leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

endmodule

// File: test/tb_scanline_irq_counter_unit.sv
// Self-checking testbench for scanline_irq_counter_unit: scanline detection, IRQ and multiplier.
// Depends on slirq_pkg and the rtl/ sources of scanline_irq_counter_unit.
module tb_scanline_irq_counter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RunLimit = 400_000;
  localparam int unsigned MaxReports = 50;

  // Tracks the counter state beat by beat and holds the results still owed by the block
  class scanline_scoreboard;
    logic [7:0]           idle_limit;
    logic [7:0]           end_line;
    logic                 saw_video;
    logic [7:0]           idle_cnt;
    logic [15:0]          nt_addr;
    logic [1:0]           hits;
    logic                 frame_on;
    logic [7:0]           line_no;
    logic [7:0]           target_line;
    logic                 irq_en;
    logic                 irq_pend;
    logic                 irq_line;
    logic [7:0]           mul_a;
    logic [7:0]           mul_b;
    slirq_pkg::out_beat_t expected_beats[$];
    int unsigned          fails;

    function new();
      idle_limit  = slirq_pkg::IdleTimeoutReset;
      end_line    = slirq_pkg::FrameEndLineReset;
      saw_video   = 1'b0;
      idle_cnt    = '0;
      nt_addr     = '0;
      hits        = '0;
      frame_on    = 1'b0;
      line_no     = '0;
      target_line = '0;
      irq_en      = 1'b0;
      irq_pend    = 1'b0;
      irq_line    = 1'b0;
      mul_a       = slirq_pkg::FactorReset;
      mul_b       = slirq_pkg::FactorReset;
      fails       = 0;
    endfunction

    function void write_reg(slirq_pkg::cfg_index_e idx, logic [7:0] value);
      case (idx)
        slirq_pkg::CFG_IDLE_TIMEOUT:   idle_limit = value;
        slirq_pkg::CFG_FRAME_END_LINE: end_line = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Third matching name-table read: start a frame, advance one line, or end the frame at the end line
    function void take_line();
      if (!frame_on) begin
        frame_on = 1'b1;
        line_no  = '0;
        irq_line = 1'b0;
      end else begin
        line_no = line_no + 8'd1;
        if (line_no == end_line) begin
          frame_on = 1'b0;
          line_no  = '0;
          irq_pend = 1'b0;
          irq_line = 1'b0;
        end else if (line_no == target_line) begin
          irq_pend = 1'b1;
          if (irq_en) irq_line = 1'b1;
        end
      end
    endfunction

    function void note_access(slirq_pkg::in_beat_t b);
      logic [15:0]          product;
      slirq_pkg::out_beat_t want;
      product        = mul_a * mul_b;
      want.read_data = '0;
      case (b.action)
        slirq_pkg::ACT_TICK: begin
          if (saw_video) begin
            idle_cnt = '0;
          end else begin
            if (idle_cnt != slirq_pkg::IdleMax) idle_cnt = idle_cnt + 8'd1;
            if (idle_cnt == idle_limit) frame_on = 1'b0;
          end
          saw_video = 1'b0;
        end
        slirq_pkg::ACT_READ: begin
          case (b.address)
            slirq_pkg::AddrStatus: begin
              want.read_data = {irq_pend, frame_on, 6'd0};
              irq_pend = 1'b0;
              irq_line = 1'b0;
            end
            slirq_pkg::AddrProdLo: want.read_data = product[7:0];
            slirq_pkg::AddrProdHi: want.read_data = product[15:8];
            slirq_pkg::AddrVectorLo, slirq_pkg::AddrVectorHi: begin
              frame_on = 1'b0;
              line_no  = '0;
              irq_pend = 1'b0;
              irq_line = 1'b0;
            end
            default: ;
          endcase
        end
        slirq_pkg::ACT_WRITE: begin
          case (b.address)
            slirq_pkg::AddrLineTarget: target_line = b.write_data;
            slirq_pkg::AddrStatus: begin
              irq_en = b.write_data[7];
              if (irq_en && irq_pend) irq_line = 1'b1;
            end
            slirq_pkg::AddrProdLo: mul_a = b.write_data;
            slirq_pkg::AddrProdHi: mul_b = b.write_data;
            default: ;
          endcase
        end
        default: begin
          saw_video = 1'b1;
          if (hits == 2'd0 && b.address[15:12] == slirq_pkg::NameTableNibble) begin
            nt_addr = b.address;
            hits    = 2'd1;
          end else if (b.address != nt_addr) begin
            hits = 2'd0;
          end else if (hits != slirq_pkg::RepeatFull) begin
            hits = hits + 2'd1;
            if (hits == slirq_pkg::RepeatFull) take_line();
          end
        end
      endcase
      want.irq_out      = irq_line;
      want.frame_active = frame_on;
      expected_beats.push_back(want);
    endfunction

    function void report(string what, logic [7:0] want, logic [7:0] got);
      if (fails < MaxReports)
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
      fails++;
    endfunction

    function void check_result(slirq_pkg::out_beat_t got);
      slirq_pkg::out_beat_t want;
      if (expected_beats.size() == 0) begin
        if (fails < MaxReports)
          $display("%0t: result beat with nothing expected, expected none, actual %p",
                   $time, got);
        fails++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.read_data !== want.read_data)
        report("read_data", want.read_data, got.read_data);
      if (got.irq_out !== want.irq_out)
        report("irq_out", 8'(want.irq_out), 8'(got.irq_out));
      if (got.frame_active !== want.frame_active)
        report("frame_active", 8'(want.frame_active), 8'(got.frame_active));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  slirq_pkg::cfg_index_e         cfg_index_i = slirq_pkg::CFG_IDLE_TIMEOUT;
  logic [slirq_pkg::CfgWidth-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  slirq_pkg::in_beat_t           in_beat_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  slirq_pkg::out_beat_t          out_beat_o;

  scanline_scoreboard sb = new();
  bit                 quiet = 1'b0;
  int unsigned        beats_sent = 0;
  int unsigned        cycle_count = 0;

  scanline_irq_counter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one beat and hold it until the block takes it
  task automatic send_beat(slirq_pkg::in_beat_t b);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 50) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(b);
    beats_sent++;
  endtask

  task automatic send_item(slirq_pkg::action_e act, logic [15:0] addr, logic [7:0] data);
    slirq_pkg::in_beat_t b;
    b.action     = act;
    b.address    = addr;
    b.write_data = data;
    send_beat(b);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] tmo, logic [7:0] fend);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= slirq_pkg::CFG_IDLE_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    sb.write_reg(slirq_pkg::CFG_IDLE_TIMEOUT, tmo);
    cfg_index_i <= slirq_pkg::CFG_FRAME_END_LINE;
    cfg_wdata_i <= fend;
    @(posedge clk_i);
    sb.write_reg(slirq_pkg::CFG_FRAME_END_LINE, fend);
    cfg_we_i <= 1'b0;
  endtask

  // Name-table reads of one address, sometimes broken, over-long or split by ticks
  task automatic line_triple();
    logic [15:0] row;
    int          reps;
    int          brk;
    row  = {slirq_pkg::NameTableNibble, 12'($urandom)};
    reps = ($urandom_range(0, 9) == 0) ? 4 : 3;
    brk  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : -1;
    for (int i = 0; i < reps; i++) begin
      if (i == brk) send_item(slirq_pkg::ACT_VIDEO, 16'($urandom), 8'($urandom));
      else send_item(slirq_pkg::ACT_VIDEO, row, 8'($urandom));
      if ($urandom_range(0, 6) == 0)
        send_item(slirq_pkg::ACT_TICK, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic cpu_access();
    logic [7:0] target;
    target = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    case ($urandom_range(0, 9))
      0: send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrStatus, 8'($urandom));
      1: send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrProdLo, 8'($urandom));
      2: send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrProdHi, 8'($urandom));
      3: send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrLineTarget, target);
      4: send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrStatus, 8'($urandom));
      5: send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrProdLo, 8'($urandom));
      6: send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrProdHi, 8'($urandom));
      7: begin
        if ($urandom_range(0, 3) == 0)
          send_item(slirq_pkg::ACT_READ,
                    $urandom_range(0, 1) ? slirq_pkg::AddrVectorHi : slirq_pkg::AddrVectorLo,
                    8'($urandom));
        else
          send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrStatus, 8'($urandom));
      end
      8: send_item(slirq_pkg::ACT_READ, 16'($urandom), 8'($urandom));
      default: send_item(slirq_pkg::ACT_WRITE, 16'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic run_random(int unsigned n, logic [7:0] tmo);
    int unsigned first;
    int          pick;
    int          ticks;
    first = beats_sent;
    while (beats_sent - first < n) begin
      if ($urandom_range(0, 19) == 0) quiet = ~quiet;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        line_triple();
      end else if (pick < 60) begin
        ticks = ($urandom_range(0, 9) == 0) ? ((tmo < 40) ? int'(tmo) + 2 : 40)
                                            : $urandom_range(1, 5);
        repeat (ticks) send_item(slirq_pkg::ACT_TICK, 16'($urandom), 8'($urandom));
      end else if (pick < 85) begin
        cpu_access();
      end else begin
        send_item(slirq_pkg::action_e'(2'($urandom_range(0, 3))), 16'($urandom),
                  8'($urandom));
      end
    end
  endtask

  task automatic run_phase(logic [7:0] tmo, logic [7:0] fend, int unsigned n);
    settle();
    set_config(tmo, fend);
    // Drive the idle counter up to its ceiling, where it saturates
    if (tmo == slirq_pkg::IdleMax) begin
      line_triple();
      repeat (260) send_item(slirq_pkg::ACT_TICK, 16'h0000, 8'h00);
    end
    run_random(n, tmo);
  endtask

  // Result side: check each beat, idle at random, and hold off once for a long stretch
  initial begin : result_side
    int unsigned hold;
    int unsigned seen;
    bit          stall_done;
    hold       = 0;
    seen       = 0;
    stall_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_beat_o);
        seen++;
      end
      if (!stall_done && seen >= 300 && in_valid_i) begin
        hold       = 250;
        stall_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        hold = gap_len() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Give up on a hung run
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > RunLimit) begin
        $display("scanline_irq_counter_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: registers at reset, factor extremes, IRQ path, unmapped and vector accesses
    send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrStatus, 8'h00);
    send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrProdLo, 8'h00);
    send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrProdHi, 8'h00);
    send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrProdLo, 8'h00);
    send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrProdLo, 8'h00);
    send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrProdHi, 8'hFF);
    send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrProdLo, 8'hFF);
    send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrLineTarget, 8'h01);
    send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrStatus, 8'h80);
    repeat (3) send_item(slirq_pkg::ACT_VIDEO, 16'h2000, 8'h00);
    repeat (3) send_item(slirq_pkg::ACT_VIDEO, 16'h2FFF, 8'h00);
    send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrStatus, 8'h00);
    send_item(slirq_pkg::ACT_WRITE, 16'hFFFF, 8'hFF);
    send_item(slirq_pkg::ACT_READ, 16'h0000, 8'h00);
    send_item(slirq_pkg::ACT_VIDEO, 16'h3000, 8'h00);
    send_item(slirq_pkg::ACT_VIDEO, 16'h1FFF, 8'h00);
    send_item(slirq_pkg::ACT_TICK, 16'h0000, 8'h00);
    send_item(slirq_pkg::ACT_TICK, 16'hFFFF, 8'hFF);
    send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrVectorLo, 8'h00);
    send_item(slirq_pkg::ACT_READ, slirq_pkg::AddrVectorHi, 8'h00);
    send_item(slirq_pkg::ACT_WRITE, slirq_pkg::AddrStatus, 8'h00);

    // Random phases across register settings, extremes included
    run_phase(8'd1, 8'd1, 100);
    run_phase(8'd3, 8'd4, 100);
    run_phase(8'd255, 8'd255, 100);
    run_phase(8'd12, 8'd9, 100);
    run_phase(8'd40, 8'd20, 100);
    run_phase(slirq_pkg::IdleTimeoutReset, slirq_pkg::FrameEndLineReset, 100);

    settle();
    if (sb.fails == 0) begin
      $display("scanline_irq_counter_unit regression: pass");
    end else begin
      $display("scanline_irq_counter_unit regression: fail");
    end
    $finish;
  end

endmodule
